// File: hw/rtl/lrs_pkg.sv
// Shared types, sizes and operation codes for the LRU replacement store.
package lrs_pkg;

    // Built depth of the entry file and key width
    localparam int ENTRIES   = 16;
    localparam int KEY_WIDTH = 32;

    // Derived widths
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // Fixed field widths of the item formats
    localparam int OP_W  = 3;
    localparam int CAP_W = 5;
    localparam int OCC_W = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_QUERY  = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_PEEK   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    // Reset value of the capacity register
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic [OP_W-1:0]      opcode;
        logic [KEY_WIDTH-1:0] key;
    } in_item_t;

    typedef struct packed {
        logic                 hit;
        logic                 evicted_valid;
        logic [KEY_WIDTH-1:0] evicted_key;
        logic                 lru_valid;
        logic [KEY_WIDTH-1:0] lru_key;
        logic [OCC_W-1:0]     occupancy;
        logic                 is_empty;
        logic                 is_full;
    } out_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic lookup;
        logic update;
        logic report;
    } dp_cmd_t;

endpackage

// File: hw/rtl/lrs_datapath.sv
// Entry file, parallel key compare, recency rank update and result register.
module lrs_datapath (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  lrs_pkg::dp_cmd_t          cmd,
    input  lrs_pkg::in_item_t         in_item,
    input  logic                      cfg_we,
    input  logic [lrs_pkg::CAP_W-1:0] cfg_data,
    output lrs_pkg::out_item_t        out_item
);

    localparam int N  = lrs_pkg::ENTRIES;
    localparam int KW = lrs_pkg::KEY_WIDTH;
    localparam int IW = lrs_pkg::IDX_W;
    localparam int CW = lrs_pkg::CNT_W;

    // Stored state
    logic [KW-1:0]            keys_reg  [N];
    logic [KW-1:0]            keys_next [N];
    logic [N-1:0]             valid_reg, valid_next;
    logic [IW-1:0]            rank_reg  [N];
    logic [IW-1:0]            rank_next [N];
    logic [CW-1:0]            count_reg, count_next;
    logic [lrs_pkg::CAP_W-1:0] cap_reg;

    // Captured item and lookup results
    logic [lrs_pkg::OP_W-1:0] op_reg;
    logic [KW-1:0]            key_reg;
    logic [N-1:0]             hit_vec_reg, hit_vec_next;
    logic [N-1:0]             old_vec_reg, old_vec_next;
    logic                     full_reg;

    // Update results
    logic                     hit_reg, hit_next;
    logic                     ev_valid_reg, ev_valid_next;
    logic [KW-1:0]            ev_key_reg, ev_key_next;

    lrs_pkg::out_item_t       out_reg, out_next;

    // Effective capacity, clamped to 1..ENTRIES
    logic [CW-1:0] eff_cap;
    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = CW'(1);
        end else if ({{(32-lrs_pkg::CAP_W){1'b0}}, cap_reg} > N) begin
            eff_cap = CW'(N);
        end else begin
            eff_cap = CW'(cap_reg);
        end
    end

    logic is_full_now;
    assign is_full_now = ({{(32-CW){1'b0}}, count_reg} >= {{(32-CW){1'b0}}, eff_cap});

    // Parallel compare: matching entry and least recent entry
    always_comb begin
        for (int i = 0; i < N; i++) begin
            hit_vec_next[i] = valid_reg[i] && (keys_reg[i] == key_reg);
            old_vec_next[i] = valid_reg[i] && ((CW'(rank_reg[i]) + CW'(1)) == count_reg);
        end
    end

    // One-hot selects of the matched and oldest entries
    logic [IW-1:0] hit_rank, old_rank;
    logic [KW-1:0] hit_key, old_key;
    always_comb begin
        hit_rank = '0;
        old_rank = '0;
        hit_key  = '0;
        old_key  = '0;
        for (int i = 0; i < N; i++) begin
            hit_rank = hit_rank | (hit_vec_reg[i] ? rank_reg[i] : '0);
            old_rank = old_rank | (old_vec_reg[i] ? rank_reg[i] : '0);
            hit_key  = hit_key  | (hit_vec_reg[i] ? keys_reg[i] : '0);
            old_key  = old_key  | (old_vec_reg[i] ? keys_reg[i] : '0);
        end
    end

    // State update for the captured operation
    always_comb begin
        logic         hit_any;
        logic         evict;
        logic [N-1:0] free_oh;

        hit_any       = |hit_vec_reg;
        evict         = 1'b0;
        free_oh       = '0;
        valid_next    = valid_reg;
        count_next    = count_reg;
        hit_next      = 1'b0;
        ev_valid_next = 1'b0;
        ev_key_next   = '0;
        for (int i = 0; i < N; i++) begin
            keys_next[i] = keys_reg[i];
            rank_next[i] = rank_reg[i];
        end

        unique case (op_reg)
            lrs_pkg::OP_QUERY, lrs_pkg::OP_INSERT: begin
                if (hit_any) begin
                    // touch: younger entries age by one, match becomes most recent
                    hit_next = 1'b1;
                    for (int i = 0; i < N; i++) begin
                        if (hit_vec_reg[i]) begin
                            rank_next[i] = '0;
                        end else if (valid_reg[i] && rank_reg[i] < hit_rank) begin
                            rank_next[i] = rank_reg[i] + IW'(1);
                        end
                    end
                end else if (op_reg == lrs_pkg::OP_INSERT) begin
                    // drop the oldest entry when full
                    evict = full_reg && (|old_vec_reg);
                    if (evict) begin
                        ev_valid_next = 1'b1;
                        ev_key_next   = old_key;
                        valid_next    = valid_reg & ~old_vec_reg;
                        count_next    = count_reg - CW'(1);
                        for (int i = 0; i < N; i++) begin
                            if (valid_next[i] && rank_reg[i] > old_rank) begin
                                rank_next[i] = rank_reg[i] - IW'(1);
                            end
                        end
                    end
                    // add the new key in the lowest free slot
                    free_oh = ~valid_next & (valid_next + N'(1));
                    if (|free_oh) begin
                        for (int i = 0; i < N; i++) begin
                            if (free_oh[i]) begin
                                keys_next[i] = key_reg;
                                rank_next[i] = '0;
                            end else if (valid_next[i]) begin
                                rank_next[i] = rank_next[i] + IW'(1);
                            end
                        end
                        valid_next = valid_next | free_oh;
                        count_next = count_next + CW'(1);
                    end
                end
            end
            lrs_pkg::OP_REMOVE: begin
                if (hit_any) begin
                    hit_next    = 1'b1;
                    ev_key_next = hit_key;
                    valid_next  = valid_reg & ~hit_vec_reg;
                    count_next  = count_reg - CW'(1);
                    for (int i = 0; i < N; i++) begin
                        if (valid_next[i] && rank_reg[i] > hit_rank) begin
                            rank_next[i] = rank_reg[i] - IW'(1);
                        end
                    end
                end
            end
            lrs_pkg::OP_CLEAR: begin
                valid_next = '0;
                count_next = '0;
                for (int i = 0; i < N; i++) begin
                    rank_next[i] = '0;
                end
            end
            default: begin
                // peek and unused codes leave the store untouched
            end
        endcase
    end

    // Rescan of the updated store for the least recent entry
    always_comb begin
        logic [KW-1:0] lru_key;
        logic          lru_found;

        lru_key   = '0;
        lru_found = 1'b0;
        for (int i = 0; i < N; i++) begin
            if (valid_reg[i] && ((CW'(rank_reg[i]) + CW'(1)) == count_reg)) begin
                lru_found = 1'b1;
                lru_key   = lru_key | keys_reg[i];
            end
        end
        out_next.hit           = hit_reg;
        out_next.evicted_valid = ev_valid_reg;
        out_next.evicted_key   = ev_key_reg;
        out_next.lru_valid     = lru_found && (op_reg == lrs_pkg::OP_PEEK);
        out_next.lru_key       = lru_key;
        out_next.occupancy     = lrs_pkg::OCC_W'(count_reg);
        out_next.is_empty      = (count_reg == '0);
        out_next.is_full       = is_full_now;
    end

    // Control state: valid bits, ranks, count, capacity
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
            cap_reg   <= lrs_pkg::CAP_RESET;
            for (int i = 0; i < N; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_data;
            end
            if (cmd.update) begin
                valid_reg <= valid_next;
                count_reg <= count_next;
                for (int i = 0; i < N; i++) begin
                    rank_reg[i] <= rank_next[i];
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= in_item.opcode;
            key_reg <= in_item.key;
        end
        if (cmd.lookup) begin
            hit_vec_reg <= hit_vec_next;
            old_vec_reg <= old_vec_next;
            full_reg    <= is_full_now;
        end
        if (cmd.update) begin
            hit_reg      <= hit_next;
            ev_valid_reg <= ev_valid_next;
            ev_key_reg   <= ev_key_next;
            for (int i = 0; i < N; i++) begin
                keys_reg[i] <= keys_next[i];
            end
        end
        if (cmd.report) begin
            out_reg <= out_next;
        end
    end

    assign out_item = out_reg;

endmodule

// File: hw/rtl/lrs_ctrl.sv
// Sequencer for lookup, update and report of one item, plus result valid.
module lrs_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output lrs_pkg::dp_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE,
        ST_REPORT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    // Command decode
    always_comb begin
        cmd.load   = (state_reg == ST_IDLE) && s_valid;
        cmd.lookup = (state_reg == ST_LOOKUP);
        cmd.update = (state_reg == ST_UPDATE);
        cmd.report = (state_reg == ST_REPORT) && out_free;
    end

    // Next state and result valid
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                state_next = ST_REPORT;
            end
            ST_REPORT: begin
                // wait for the output register to drain
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// File: hw/rtl/lru_replacement_store_top.sv
// Top level of the fully associative LRU replacement store.
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    s_item   (opcode, key)
//  m_        out        m_valid / m_ready    m_item   (hit, evicted, lru, status)
//  cfg_      in         cfg_valid/cfg_ready  cfg_data (capacity)
//
// An item passes through accept, parallel compare over the entry file, rank update,
// and a rescan of the updated file that loads the result register.
// A new item is accepted only once the previous one has passed its compare/update/
// rescan sequence, which runs on the single entry file.
// Reset, sampled on the clock edge, clears valid bits, ranks and count and sets capacity to 16.
// A stalled result holds in its register; the next item is accepted meanwhile
// and its report step waits until the register drains.
module lru_replacement_store_top (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  lrs_pkg::in_item_t         s_item,
    output logic                      m_valid,
    input  logic                      m_ready,
    output lrs_pkg::out_item_t        m_item,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [lrs_pkg::CAP_W-1:0] cfg_data
);

    lrs_pkg::dp_cmd_t cmd;

    // Configuration is always taken
    assign cfg_ready = 1'b1;

    lrs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    lrs_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_item  (s_item),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .out_item (m_item)
    );

endmodule

// File: hw/rtl/lrs_checker.sv
// Port-level checks on the LRU replacement store, bound to the top level.
module lrs_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input lrs_pkg::out_item_t m_item
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // Empty flag tracks occupancy
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.is_empty == (m_item.occupancy == '0)))
        else $error("is_empty disagrees with occupancy");

    // An eviction only happens on a miss and leaves the store full
    a_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.evicted_valid |-> !m_item.hit && m_item.is_full)
        else $error("eviction without a full store or on a hit");

    // A successful peek implies a nonempty store and no eviction
    a_peek: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.lru_valid |-> !m_item.is_empty && !m_item.evicted_valid)
        else $error("peek reported a key from an empty store");

endmodule

bind lru_replacement_store_top lrs_checker u_lrs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

// File: sim/lru_replacement_store_top_test.sv
// Self-checking testbench for the LRU replacement store: directed rows, then random phases.
module lru_replacement_store_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Opcodes the block leaves unused
    localparam logic [lrs_pkg::OP_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [lrs_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [lrs_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam int unsigned CYCLE_LIMIT = 250_000;
    localparam int unsigned PHASE_ITEMS = 94;
    localparam int unsigned MAX_REPORTS = 10;

    typedef enum logic {ROW_ITEM, ROW_CAP} row_kind_t;

    typedef struct {
        row_kind_t                 kind;
        lrs_pkg::in_item_t         item;
        logic [lrs_pkg::CAP_W-1:0] cap;
        bit                        known;
        lrs_pkg::out_item_t        result;
    } stim_row_t;

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    lrs_pkg::in_item_t         s_item;
    logic                      m_valid;
    logic                      m_ready;
    lrs_pkg::out_item_t        m_item;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [lrs_pkg::CAP_W-1:0] cfg_data;

    // Shadow copy of the entry file
    logic [lrs_pkg::KEY_WIDTH-1:0] held_key  [lrs_pkg::ENTRIES];
    bit                            held_vld  [lrs_pkg::ENTRIES];
    int unsigned                   held_rank [lrs_pkg::ENTRIES];
    int unsigned                   held_count;
    logic [lrs_pkg::CAP_W-1:0]     cap_setting;

    lrs_pkg::out_item_t            awaited_results[$];
    stim_row_t                     dir_rows[$];
    logic [lrs_pkg::KEY_WIDTH-1:0] key_pool[$];
    logic [lrs_pkg::CAP_W-1:0]     phase_caps[8] =
        '{5'd1, 5'd16, 5'd4, 5'd0, 5'd31, 5'd8, 5'd2, 5'd12};

    int unsigned cycle_cnt = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned results_seen = 0;
    int unsigned items_sent = 0;
    int unsigned hit_cnt = 0;
    int unsigned evict_cnt = 0;
    int unsigned cap_writes = 0;
    int unsigned peak_occ = 0;
    bit          src_calm = 1'b0;
    bit          sink_calm = 1'b0;

    lru_replacement_store_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // ---------------------------------------------------------------
    // Shadow model of the store
    // ---------------------------------------------------------------

    // Capacity 0 behaves as 1, anything past the built depth as the depth
    function automatic int unsigned eff_capacity();
        if (cap_setting < 1) return 1;
        if (cap_setting > lrs_pkg::ENTRIES) return lrs_pkg::ENTRIES;
        return cap_setting;
    endfunction

    function automatic int slot_of(logic [lrs_pkg::KEY_WIDTH-1:0] k);
        for (int i = 0; i < lrs_pkg::ENTRIES; i++)
            if (held_vld[i] && held_key[i] == k) return i;
        return -1;
    endfunction

    function automatic int oldest_slot();
        for (int i = 0; i < lrs_pkg::ENTRIES; i++)
            if (held_vld[i] && held_rank[i] + 1 == held_count) return i;
        return -1;
    endfunction

    function automatic void make_newest(int slot);
        int unsigned r;
        r = held_rank[slot];
        for (int i = 0; i < lrs_pkg::ENTRIES; i++)
            if (held_vld[i] && held_rank[i] < r) held_rank[i]++;
        held_rank[slot] = 0;
    endfunction

    function automatic void retire_slot(int slot);
        int unsigned r;
        r = held_rank[slot];
        held_vld[slot] = 1'b0;
        for (int i = 0; i < lrs_pkg::ENTRIES; i++)
            if (held_vld[i] && held_rank[i] > r) held_rank[i]--;
        if (held_count > 0) held_count--;
    endfunction

    function automatic void place_key(logic [lrs_pkg::KEY_WIDTH-1:0] k);
        int slot;
        slot = -1;
        for (int i = 0; i < lrs_pkg::ENTRIES; i++)
            if (!held_vld[i] && slot < 0) slot = i;
        if (slot < 0) return;
        for (int i = 0; i < lrs_pkg::ENTRIES; i++)
            if (held_vld[i]) held_rank[i]++;
        held_vld[slot]  = 1'b1;
        held_key[slot]  = k;
        held_rank[slot] = 0;
        held_count++;
    endfunction

    // Applies one item to the shadow store and returns the result it causes
    function automatic lrs_pkg::out_item_t next_result(lrs_pkg::in_item_t it);
        lrs_pkg::out_item_t r;
        int slot;
        r = '0;
        slot = slot_of(it.key);
        case (it.opcode)
            lrs_pkg::OP_QUERY: begin
                if (slot >= 0) begin
                    r.hit = 1'b1;
                    make_newest(slot);
                end
            end
            lrs_pkg::OP_INSERT: begin
                if (slot >= 0) begin
                    r.hit = 1'b1;
                    make_newest(slot);
                end else begin
                    if (held_count >= eff_capacity()) begin
                        slot = oldest_slot();
                        if (slot >= 0) begin
                            r.evicted_valid = 1'b1;
                            r.evicted_key   = held_key[slot];
                            retire_slot(slot);
                        end
                    end
                    place_key(it.key);
                end
            end
            lrs_pkg::OP_REMOVE: begin
                if (slot >= 0) begin
                    r.hit         = 1'b1;
                    r.evicted_key = held_key[slot];
                    retire_slot(slot);
                end
            end
            lrs_pkg::OP_CLEAR: begin
                for (int i = 0; i < lrs_pkg::ENTRIES; i++) begin
                    held_vld[i]  = 1'b0;
                    held_rank[i] = 0;
                end
                held_count = 0;
            end
            default: ;
        endcase
        slot = oldest_slot();
        if (slot >= 0) begin
            r.lru_key   = held_key[slot];
            r.lru_valid = (it.opcode == lrs_pkg::OP_PEEK);
        end
        r.occupancy = lrs_pkg::OCC_W'(held_count);
        r.is_empty  = (held_count == 0);
        r.is_full   = (held_count >= eff_capacity());
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Directed rows
    // ---------------------------------------------------------------

    function automatic lrs_pkg::out_item_t result_of(bit hit, bit ev_vld,
                                                     logic [lrs_pkg::KEY_WIDTH-1:0] ev_key,
                                                     bit lru_vld,
                                                     logic [lrs_pkg::KEY_WIDTH-1:0] lru_key,
                                                     int unsigned occ, bit empty, bit full);
        lrs_pkg::out_item_t r;
        r.hit           = hit;
        r.evicted_valid = ev_vld;
        r.evicted_key   = ev_key;
        r.lru_valid     = lru_vld;
        r.lru_key       = lru_key;
        r.occupancy     = lrs_pkg::OCC_W'(occ);
        r.is_empty      = empty;
        r.is_full       = full;
        return r;
    endfunction

    function automatic void add_op(logic [lrs_pkg::OP_W-1:0] op,
                                   logic [lrs_pkg::KEY_WIDTH-1:0] key);
        stim_row_t row;
        row.kind        = ROW_ITEM;
        row.item.opcode = op;
        row.item.key    = key;
        row.cap         = '0;
        row.known       = 1'b0;
        row.result      = '0;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_known(logic [lrs_pkg::OP_W-1:0] op,
                                      logic [lrs_pkg::KEY_WIDTH-1:0] key,
                                      lrs_pkg::out_item_t r);
        add_op(op, key);
        dir_rows[$].known  = 1'b1;
        dir_rows[$].result = r;
    endfunction

    function automatic void add_cap(logic [lrs_pkg::CAP_W-1:0] v);
        stim_row_t row;
        row.kind   = ROW_CAP;
        row.item   = '0;
        row.cap    = v;
        row.known  = 1'b0;
        row.result = '0;
        dir_rows.push_back(row);
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------

    // Offers one item after a random gap and files its expected result on acceptance
    task automatic send_op(lrs_pkg::in_item_t it, bit known, lrs_pkg::out_item_t known_result);
        int unsigned        gap;
        lrs_pkg::out_item_t r;
        if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
        gap = src_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r = next_result(it);
        if (known) r = known_result;
        awaited_results.push_back(r);
        items_sent++;
        if (r.hit) hit_cnt++;
        if (r.evicted_valid) evict_cnt++;
        if (r.occupancy > peak_occ) peak_occ = r.occupancy;
    endtask

    // Capacity changes only with nothing in flight
    task automatic write_capacity(logic [lrs_pkg::CAP_W-1:0] v);
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid   <= 1'b0;
        cap_setting = v;
        cap_writes++;
    endtask

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin : stimulus
        lrs_pkg::in_item_t it;
        int unsigned       pick;
        int unsigned       pool_n;

        s_valid   <= 1'b0;
        s_item    <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        aresetn   <= 1'b0;
        for (int i = 0; i < lrs_pkg::ENTRIES; i++) begin
            held_key[i]  = '0;
            held_vld[i]  = 1'b0;
            held_rank[i] = 0;
        end
        held_count  = 0;
        cap_setting = lrs_pkg::CAP_RESET;

        // Empty store, misses, spare opcodes, fill, touch, remove
        add_known(lrs_pkg::OP_PEEK,   32'h0000_0000, result_of(0, 0, 0, 0, 0, 0, 1, 0));
        add_known(lrs_pkg::OP_QUERY,  32'hFFFF_FFFF, result_of(0, 0, 0, 0, 0, 0, 1, 0));
        add_known(lrs_pkg::OP_REMOVE, 32'h1234_5678, result_of(0, 0, 0, 0, 0, 0, 1, 0));
        add_known(OP_SPARE_5,         32'h0000_0000, result_of(0, 0, 0, 0, 0, 0, 1, 0));
        add_known(OP_SPARE_7,         32'hFFFF_FFFF, result_of(0, 0, 0, 0, 0, 0, 1, 0));
        add_known(lrs_pkg::OP_INSERT, 32'h0000_0000, result_of(0, 0, 0, 0, 0, 1, 0, 0));
        add_op(lrs_pkg::OP_INSERT, 32'hFFFF_FFFF);
        add_op(lrs_pkg::OP_INSERT, 32'hA5A5_A5A5);
        add_op(lrs_pkg::OP_INSERT, 32'h5A5A_5A5A);
        add_op(lrs_pkg::OP_QUERY,  32'h0000_0000);
        add_op(lrs_pkg::OP_INSERT, 32'hFFFF_FFFF);
        add_op(lrs_pkg::OP_REMOVE, 32'hA5A5_A5A5);
        add_op(lrs_pkg::OP_REMOVE, 32'hA5A5_A5A5);
        add_op(lrs_pkg::OP_PEEK,   32'h0000_0000);
        add_op(OP_SPARE_6,         32'h0000_0000);
        // Capacity dropped below occupancy: inserts evict one each, occupancy holds
        add_cap(5'd2);
        add_op(lrs_pkg::OP_INSERT, 32'h1111_1111);
        add_op(lrs_pkg::OP_INSERT, 32'h2222_2222);
        add_op(lrs_pkg::OP_QUERY,  32'h5A5A_5A5A);
        // Capacity zero acts as one
        add_cap(5'd0);
        add_op(lrs_pkg::OP_INSERT, 32'h3333_3333);
        add_op(lrs_pkg::OP_PEEK,   32'h0000_0000);
        add_known(lrs_pkg::OP_CLEAR,  32'h0000_0000, result_of(0, 0, 0, 0, 0, 0, 1, 0));
        add_known(lrs_pkg::OP_INSERT, 32'hDEAD_BEEF,
                  result_of(0, 0, 0, 0, 32'hDEAD_BEEF, 1, 0, 1));
        add_known(lrs_pkg::OP_INSERT, 32'h00C0_FFEE,
                  result_of(0, 1, 32'hDEAD_BEEF, 0, 32'h00C0_FFEE, 1, 0, 1));
        // Capacity beyond the built depth
        add_cap(5'd31);
        add_op(lrs_pkg::OP_INSERT, 32'h8000_0000);
        add_op(lrs_pkg::OP_CLEAR,  32'hFFFF_FFFF);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[n]) begin
            if (dir_rows[n].kind == ROW_CAP) begin
                write_capacity(dir_rows[n].cap);
            end else begin
                send_op(dir_rows[n].item, dir_rows[n].known, dir_rows[n].result);
            end
        end

        // Random phases; no clear in between, so a lower capacity meets a fuller store
        phase_caps[7] = lrs_pkg::CAP_W'($urandom_range(0, 31));
        foreach (phase_caps[p]) begin
            write_capacity(phase_caps[p]);
            key_pool.delete();
            pool_n = eff_capacity() + $urandom_range(1, 6);
            repeat (pool_n) key_pool.push_back($urandom());
            repeat (PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    it.opcode = lrs_pkg::OP_INSERT;
                end else if (pick < 65) begin
                    it.opcode = lrs_pkg::OP_QUERY;
                end else if (pick < 80) begin
                    it.opcode = lrs_pkg::OP_REMOVE;
                end else if (pick < 91) begin
                    it.opcode = lrs_pkg::OP_PEEK;
                end else if (pick < 92) begin
                    it.opcode = lrs_pkg::OP_CLEAR;
                end else begin
                    case ($urandom_range(0, 2))
                        0: it.opcode = OP_SPARE_5;
                        1: it.opcode = OP_SPARE_6;
                        default: it.opcode = OP_SPARE_7;
                    endcase
                end
                // mostly pooled keys so hits and evictions happen, some fresh noise
                if ($urandom_range(0, 11) == 0) begin
                    it.key = $urandom();
                end else begin
                    it.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
                end
                send_op(it, 1'b0, '0);
            end
        end

        // Drain, then a short tail for stray results
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);

        $display("run: %0d items, %0d results, %0d capacity writes (0, 1, 2, 16, 31 among them)",
                 items_sent, results_seen, cap_writes);
        $display("run: %0d hits, %0d evictions, peak occupancy %0d, %0d mismatches",
                 hit_cnt, evict_cnt, peak_occ, mismatch_cnt);
        if (mismatch_cnt == 0 && awaited_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // ---------------------------------------------------------------
    // Result side: random stalls, compare against oldest expectation
    // ---------------------------------------------------------------
    initial begin : result_sink
        int unsigned        stall;
        lrs_pkg::out_item_t want;
        lrs_pkg::out_item_t got;

        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
            stall = sink_calm ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            got = m_item;
            results_seen++;
            if (awaited_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("ERROR: unexpected result %0d: %p", results_seen, got);
            end else begin
                want = awaited_results.pop_front();
                if (got.hit !== want.hit || got.evicted_valid !== want.evicted_valid ||
                    got.evicted_key !== want.evicted_key || got.lru_valid !== want.lru_valid ||
                    got.lru_key !== want.lru_key || got.occupancy !== want.occupancy ||
                    got.is_empty !== want.is_empty || got.is_full !== want.is_full) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS) begin
                        $display("ERROR: result %0d at cycle %0d", results_seen, cycle_cnt);
                        $display("  exp hit=%0b ev=%0b/%h lru=%0b/%h occ=%0d empty=%0b full=%0b",
                                 want.hit, want.evicted_valid, want.evicted_key,
                                 want.lru_valid, want.lru_key, want.occupancy,
                                 want.is_empty, want.is_full);
                        $display("  got hit=%0b ev=%0b/%h lru=%0b/%h occ=%0d empty=%0b full=%0b",
                                 got.hit, got.evicted_valid, got.evicted_key,
                                 got.lru_valid, got.lru_key, got.occupancy,
                                 got.is_empty, got.is_full);
                    end
                end
            end
        end
    end

    // Hang guard
    initial begin : watchdog
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("ERROR: no progress after %0d cycles", CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/lrs_pkg.sv
hw/rtl/lrs_datapath.sv
hw/rtl/lrs_ctrl.sv
hw/rtl/lru_replacement_store_top.sv
hw/rtl/lrs_checker.sv
sim/lru_replacement_store_top_test.sv
